// ----- src/sdmd_pkg.sv -----
// Package of the sigma-delta motion detector: sizes, register map and reset values.
package sdmd_pkg;

    // Frame store depth used when the top level is not told otherwise
    localparam int unsigned DEF_FRAME_PIXELS = 65536;

    // Field widths
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned INDEX_W = 16;

    // Configuration port
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_VAR_MIN     = 2'd0;
    localparam logic [1:0] REG_VAR_MAX     = 2'd1;
    localparam logic [1:0] REG_WHITE_LEVEL = 2'd2;

    localparam logic [PIX_W-1:0] VAR_MIN_RST     = 8'd1;
    localparam logic [PIX_W-1:0] VAR_MAX_RST     = 8'd254;
    localparam logic [PIX_W-1:0] WHITE_LEVEL_RST = 8'd255;

    // One frame store entry: background mean and variance of a pixel
    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [PIX_W-1:0] variance;
    } entry_t;

endpackage

// ----- src/sdmd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sdmd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sigma_delta_motion_detect_unit.sv -----
// Top level of the sigma-delta motion detector: stream pipeline, frame store and registers.
//
// Usage
//   Input stream (s_*): one pixel request per cycle while s_tready is high. s_tdata carries the
//   pixel intensity and its raster index; s_tuser marks an init request, which loads the
//   background mean with the pixel and the variance with var_min. Other requests update the
//   stored mean and variance of that index and label the pixel as motion or background.
//   Output stream (m_*): one result per request, in request order, carrying the label, the
//   absolute difference, and the updated mean and variance.
//   Registers (APB): var_min at 0x0, var_max at 0x4, white_level at 0x8. Write them only
//   while no request is in flight.
// Timing
//   m_tvalid follows stages 1, 2 and the output register; throughput is one request per cycle
//   unless stalled. The index is reduced over the first two stages, the store read is issued in
//   the second, and the update and write-back follow the registered read. A request that reads
//   the index being written in the same cycle gets the fresh entry through a forwarding register.
// Reset and stall
//   Reset empties the pipeline and restores the register defaults; the frame store is not
//   cleared, so each index must see an init request before a detect request. When the
//   receiver holds m_tready low with a result pending, the whole pipeline freezes and
//   s_tready drops in the same cycle.
module sigma_delta_motion_detect_unit
    import sdmd_pkg::*;
#(
    parameter int unsigned FRAME_PIXELS = DEF_FRAME_PIXELS
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // [7:0] pixel, [23:8] pixel_index
    input  logic [0:0]         s_tuser,   // [0] init_frame
    // Output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [7:0] motion_label, [15:8] abs_diff,
                                          // [23:16] new_mean, [31:24] new_variance
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam longint unsigned NPIX = longint'(FRAME_PIXELS);
    localparam int unsigned EW = $bits(entry_t);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] var_min_reg;
    logic [PIX_W-1:0] var_max_reg;
    logic [PIX_W-1:0] white_level_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_min_reg     <= VAR_MIN_RST;
            var_max_reg     <= VAR_MAX_RST;
            white_level_reg <= WHITE_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_VAR_MIN:     var_min_reg     <= pwdata[PIX_W-1:0];
                REG_VAR_MAX:     var_max_reg     <= pwdata[PIX_W-1:0];
                REG_WHITE_LEVEL: white_level_reg <= pwdata[PIX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_VAR_MIN:     prdata[PIX_W-1:0] = var_min_reg;
            REG_VAR_MAX:     prdata[PIX_W-1:0] = var_max_reg;
            REG_WHITE_LEVEL: prdata[PIX_W-1:0] = white_level_reg;
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the output register can take a result
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 1: reduce the index modulo the store depth, upper half of the subtract chain
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0] idx_a_next;
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic               s1_init_reg;

    always_comb
    begin
        idx_a_next = s_tdata[23:8];
        for (int k = 15; k >= 8; k--)
        begin
            if ((NPIX << k) < 64'd65536)
            begin
                if (idx_a_next >= INDEX_W'(NPIX << k))
                begin
                    idx_a_next = idx_a_next - INDEX_W'(NPIX << k);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= s_tdata[7:0];
            s1_idx_reg  <= idx_a_next;
            s1_init_reg <= s_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: finish the reduction and issue the frame store read
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0] idx_b;
    logic [AW-1:0]      rd_addr;
    logic               s2_valid_reg;
    logic [PIX_W-1:0]   s2_pix_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic               s2_init_reg;

    always_comb
    begin
        idx_b = s1_idx_reg;
        for (int k = 7; k >= 0; k--)
        begin
            if ((NPIX << k) < 64'd65536)
            begin
                if (idx_b >= INDEX_W'(NPIX << k))
                begin
                    idx_b = idx_b - INDEX_W'(NPIX << k);
                end
            end
        end
    end

    assign rd_addr = AW'(idx_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pix_reg  <= s1_pix_reg;
            s2_addr_reg <= rd_addr;
            s2_init_reg <= s1_init_reg;
        end
    end

    // ------------------------------------------------------------------
    // Frame store and forwarding of the entry written in the read cycle
    // ------------------------------------------------------------------
    logic            st_we;
    entry_t          st_rdata;
    entry_t          st_wdata;
    logic            fwd_valid_reg;
    logic [AW-1:0]   fwd_addr_reg;
    entry_t          fwd_data_reg;
    entry_t          cur;

    assign st_we = s2_valid_reg && adv;

    sdmd_ram #(
        .WIDTH (EW),
        .DEPTH (FRAME_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (s2_addr_reg),
        .wdata (st_wdata),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (st_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= st_wdata;
        end
    end

    // Take the entry just written when the read raced its write-back
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg : st_rdata;

    // ------------------------------------------------------------------
    // Stage 3: sigma-delta update of mean and variance, label decision
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] mean_next;
    logic [PIX_W-1:0] diff_next;
    logic [PIX_W:0]   twice;
    logic [PIX_W:0]   var_step;
    logic [PIX_W-1:0] var_next;
    logic [PIX_W-1:0] label_next;

    always_comb
    begin
        // Step the mean one toward the pixel
        if (cur.mean < s2_pix_reg)
        begin
            mean_next = cur.mean + 8'd1;
        end
        else if (cur.mean > s2_pix_reg)
        begin
            mean_next = cur.mean - 8'd1;
        end
        else
        begin
            mean_next = cur.mean;
        end

        diff_next = (mean_next > s2_pix_reg) ? (mean_next - s2_pix_reg)
                                             : (s2_pix_reg - mean_next);
        twice = {diff_next, 1'b0};

        // Step the variance one toward twice the difference, then clamp (var_min wins)
        var_step = {1'b0, cur.variance};
        if (var_step < twice)
        begin
            var_step = var_step + 9'd1;
        end
        else if (var_step > twice)
        begin
            var_step = var_step - 9'd1;
        end
        if (var_step > {1'b0, var_max_reg})
        begin
            var_step = {1'b0, var_max_reg};
        end
        if (var_step < {1'b0, var_min_reg})
        begin
            var_step = {1'b0, var_min_reg};
        end
        var_next   = var_step[PIX_W-1:0];
        label_next = ({1'b0, diff_next} < var_step) ? '0 : white_level_reg;

        // Init requests load the entry and report no motion
        if (s2_init_reg)
        begin
            mean_next  = s2_pix_reg;
            diff_next  = '0;
            var_next   = var_min_reg;
            label_next = '0;
        end
    end

    // Mean in the upper byte, variance in the lower byte
    assign st_wdata = {mean_next, var_next};

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [31:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            out_data_reg <= {var_next, mean_next, diff_next, label_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // A request in the last stage reaches the output register when the pipe moves
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && adv |=> out_valid_reg)
        else $error("result lost between update stage and output register");

    // A motion label is only raised when the difference reached the variance
    a_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg[7:0] != 8'd0) |-> out_data_reg[15:8] >= out_data_reg[31:24])
        else $error("motion label set with difference below variance");

    // The forwarding register tracks the last write-back
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |=> fwd_valid_reg && (fwd_addr_reg == $past(s2_addr_reg)))
        else $error("forwarding register missed a write-back");

    // An accepted request enters the first stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted request did not enter the pipeline");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench of the sigma-delta motion detector: directed table, random pixel streams, scoreboard.
`timescale 1ns / 100ps

module tb;
    import sdmd_pkg::*;

    // One result as it travels on m_tdata; the label sits in the lowest byte
    typedef struct packed {
        logic [7:0] new_variance;
        logic [7:0] new_mean;
        logic [7:0] abs_diff;
        logic [7:0] motion_label;
    } motion_result_t;

    // One row of the directed table. The typed result is used only when fixed is set.
    typedef struct packed {
        logic [7:0]     pixel;
        logic [15:0]    index;
        logic           init;
        logic           fixed;
        motion_result_t res;      // variance, mean, diff, label
    } pixel_req_t;

    localparam int DIRECTED_ROWS = 20;

    // Directed rows run under the reset settings: var_min 1, var_max 254, white 255.
    // Indices 0x5AA5 / 0xA55A and pixels 0x55 / 0xAA toggle every bit of both fields.
    pixel_req_t directed_rows [DIRECTED_ROWS] = '{
        // init at both ends of the index range, both pixel extremes
        '{8'h00, 16'h0000, 1'b1, 1'b1, '{8'h01, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 16'hFFFF, 1'b1, 1'b1, '{8'h01, 8'hFF, 8'h00, 8'h00}},
        // detect on an unchanged pixel: variance falls to zero and clamps to var_min
        '{8'h00, 16'h0000, 1'b0, 1'b1, '{8'h01, 8'h00, 8'h00, 8'h00}},
        '{8'hFF, 16'hFFFF, 1'b0, 1'b1, '{8'h01, 8'hFF, 8'h00, 8'h00}},
        // full-scale jump: mean steps by one, label goes white
        '{8'hFF, 16'h0000, 1'b0, 1'b1, '{8'h02, 8'h01, 8'hFE, 8'hFF}},
        // same index back to back exercises the store forwarding
        '{8'hFF, 16'h0000, 1'b0, 1'b0, '0},
        '{8'h00, 16'hFFFF, 1'b0, 1'b0, '0},
        '{8'h80, 16'h5AA5, 1'b1, 1'b1, '{8'h01, 8'h80, 8'h00, 8'h00}},
        '{8'h7F, 16'hA55A, 1'b1, 1'b1, '{8'h01, 8'h7F, 8'h00, 8'h00}},
        '{8'h81, 16'h5AA5, 1'b0, 1'b0, '0},
        '{8'h7F, 16'hA55A, 1'b0, 1'b0, '0},
        '{8'h00, 16'h5AA5, 1'b0, 1'b0, '0},
        '{8'hFF, 16'hA55A, 1'b0, 1'b0, '0},
        // re-init of an index that already holds history
        '{8'hFF, 16'h0000, 1'b1, 1'b1, '{8'h01, 8'hFF, 8'h00, 8'h00}},
        '{8'hFF, 16'h0000, 1'b0, 1'b0, '0},
        '{8'h00, 16'h0000, 1'b0, 1'b0, '0},
        '{8'h80, 16'hFFFF, 1'b0, 1'b0, '0},
        '{8'h55, 16'h0001, 1'b1, 1'b1, '{8'h01, 8'h55, 8'h00, 8'h00}},
        '{8'hAA, 16'h0001, 1'b0, 1'b0, '0},
        '{8'h55, 16'h0001, 1'b0, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;   // [7:0] pixel, [23:8] pixel_index
    logic [0:0]          s_tuser;   // [0] init_frame
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [31:0]         m_tdata;   // [7:0] label, [15:8] diff, [23:16] mean, [31:24] variance
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Background model kept by the testbench, plus its copy of the registers
    logic [7:0] bg_mean [0:65535];
    logic [7:0] bg_var  [0:65535];
    logic [7:0] cfg_var_min;
    logic [7:0] cfg_var_max;
    logic [7:0] cfg_white;

    motion_result_t pending_results [$];

    // Typed expectation of the request currently offered by the sender
    logic           drv_fixed;
    motion_result_t drv_fixed_res;

    int  mismatches = 0;
    bit  no_idle = 1'b0;
    int  rx_hold = 0;

    sigma_delta_motion_detect_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic log_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected 0x%h, got 0x%h", $time, what, want, got);
    endtask

    // Advance the background model by one request and return what the block must emit
    task automatic update_background(input logic [7:0] pix, input logic [15:0] idx,
                                     input logic init, output motion_result_t res);
        logic [7:0] m;
        logic [7:0] d;
        logic [8:0] twice;
        logic [8:0] v;
        if (init) begin
            bg_mean[idx] = pix;
            bg_var[idx]  = cfg_var_min;
            res.motion_label = 8'h00;
            res.abs_diff     = 8'h00;
            res.new_mean     = pix;
            res.new_variance = cfg_var_min;
        end
        else begin
            m = bg_mean[idx];
            if (m < pix)
                m = m + 8'd1;
            else if (m > pix)
                m = m - 8'd1;
            d = (m > pix) ? (m - pix) : (pix - m);
            // twice the difference and the stepped variance both need a ninth bit
            twice = {d, 1'b0};
            v = {1'b0, bg_var[idx]};
            if (v < twice)
                v = v + 9'd1;
            else if (v > twice)
                v = v - 9'd1;
            // upper clamp first, so var_min wins when the two cross
            if (v > {1'b0, cfg_var_max})
                v = {1'b0, cfg_var_max};
            if (v < {1'b0, cfg_var_min})
                v = {1'b0, cfg_var_min};
            bg_mean[idx] = m;
            bg_var[idx]  = v[7:0];
            res.motion_label = ({1'b0, d} < v) ? 8'h00 : cfg_white;
            res.abs_diff     = d;
            res.new_mean     = m;
            res.new_variance = v[7:0];
        end
    endtask

    // Scoreboard: check the result side first so a fresh request never answers a stray result
    always @(posedge clk) begin
        motion_result_t want;
        motion_result_t got;
        motion_result_t pred;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = motion_result_t'(m_tdata);
                if (pending_results.size() == 0) begin
                    log_mismatch("result with no request pending, label", 8'h00,
                                 got.motion_label);
                end
                else begin
                    want = pending_results.pop_front();
                    if (got.motion_label !== want.motion_label)
                        log_mismatch("motion_label", want.motion_label, got.motion_label);
                    if (got.abs_diff !== want.abs_diff)
                        log_mismatch("abs_diff", want.abs_diff, got.abs_diff);
                    if (got.new_mean !== want.new_mean)
                        log_mismatch("new_mean", want.new_mean, got.new_mean);
                    if (got.new_variance !== want.new_variance)
                        log_mismatch("new_variance", want.new_variance, got.new_variance);
                end
            end
            if (s_tvalid && s_tready) begin
                update_background(s_tdata[7:0], s_tdata[23:8], s_tuser[0], pred);
                pending_results.push_back(drv_fixed ? drv_fixed_res : pred);
            end
        end
    end

    // Receiver: drop m_tready for random stretches
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            m_tready = 1'b0;
            rx_hold--;
        end
        else begin
            m_tready = 1'b1;
            rx_hold = gap_length();
        end
    end

    // Offer one request; entered and left just after a falling edge
    task automatic send_req(input pixel_req_t r);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata       = {r.index, r.pixel};
        s_tuser       = r.init;
        drv_fixed     = r.fixed;
        drv_fixed_res = r.res;
        s_tvalid      = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] pix, input logic [15:0] idx, input logic init);
        pixel_req_t r;
        r = '0;
        r.pixel = pix;
        r.index = idx;
        r.init  = init;
        send_req(r);
    endtask

    // Stop offering requests until every result is back, then let the pipeline settle
    task automatic hold_until_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [7:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({sel, 2'b00});
        pwdata  = PDATA_W'(val);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (sel)
            REG_VAR_MIN:     cfg_var_min = val;
            REG_VAR_MAX:     cfg_var_max = val;
            REG_WHITE_LEVEL: cfg_white   = val;
            default:         ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_reg(input logic [1:0] sel, output logic [7:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = PADDR_W'({sel, 2'b00});
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        val = prdata[7:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write all three registers and read each one back
    task automatic program_setting(input logic [7:0] vmin, input logic [7:0] vmax,
                                   input logic [7:0] white);
        logic [7:0] rb;
        write_reg(REG_VAR_MIN, vmin);
        write_reg(REG_VAR_MAX, vmax);
        write_reg(REG_WHITE_LEVEL, white);
        read_reg(REG_VAR_MIN, rb);
        if (rb !== vmin)
            log_mismatch("var_min readback", vmin, rb);
        read_reg(REG_VAR_MAX, rb);
        if (rb !== vmax)
            log_mismatch("var_max readback", vmax, rb);
        read_reg(REG_WHITE_LEVEL, rb);
        if (rb !== white)
            log_mismatch("white_level readback", white, rb);
    endtask

    // One scene: a handful of pixel positions, initialized first, then tracked with noise,
    // motion jumps, re-inits and back-to-back hits on the same position.
    task automatic run_scene(input int n_detect);
        logic [15:0] pos [12];
        logic [7:0]  scene [12];
        int k;
        int last_k;
        int r;
        int r2;
        int level;
        logic [7:0] pix;
        for (k = 0; k < 12; k++) begin
            pos[k]   = (k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : 16'($urandom_range(0, 65535));
            scene[k] = 8'($urandom_range(0, 255));
            send_pixel(scene[k], pos[k], 1'b1);
        end
        last_k = 0;
        for (int i = 0; i < n_detect; i++) begin
            // hold off once per scene until the scoreboard has emptied
            if (i == n_detect / 2)
                hold_until_drained();
            r = $urandom_range(0, 99);
            if (r < 6) begin
                k = $urandom_range(0, 11);
                scene[k] = 8'($urandom_range(0, 255));
                send_pixel(scene[k], pos[k], 1'b1);
            end
            else if (r < 9) begin
                k = $urandom_range(2, 11);
                pos[k]   = 16'($urandom_range(0, 65535));
                scene[k] = 8'($urandom_range(0, 255));
                send_pixel(scene[k], pos[k], 1'b1);
            end
            else begin
                k = (r < 25) ? last_k : $urandom_range(0, 11);
                r2 = $urandom_range(0, 99);
                if (r2 < 65) begin
                    // sensor noise around the scene level
                    level = int'(scene[k]) + $urandom_range(0, 12) - 6;
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    pix = 8'(level);
                end
                else if (r2 < 80) begin
                    // an object moves in: the scene level jumps and stays
                    scene[k] = 8'($urandom_range(0, 255));
                    pix = scene[k];
                end
                else if (r2 < 90) begin
                    pix = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                end
                else begin
                    pix = 8'($urandom_range(0, 255));
                end
                send_pixel(pix, pos[k], 1'b0);
            end
            last_k = k;
        end
    endtask

    initial begin
        int waited;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        drv_fixed     = 1'b0;
        drv_fixed_res = '0;
        cfg_var_min   = VAR_MIN_RST;
        cfg_var_max   = VAR_MAX_RST;
        cfg_white     = WHITE_LEVEL_RST;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table under the reset register values
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_req(directed_rows[i]);
        hold_until_drained();

        // Random scenes, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            hold_until_drained();
            no_idle = (p == 3);
            case (p)
                0: program_setting(VAR_MIN_RST, VAR_MAX_RST, WHITE_LEVEL_RST);
                1: program_setting(8'd0, 8'd255, 8'd1);
                2: program_setting(8'd255, 8'd0, 8'd128);  // var_min above var_max
                3: program_setting(8'd0, 8'd0, 8'd0);
                4: program_setting(8'd255, 8'd255, 8'd255);
                5: program_setting(8'd16, 8'd40, 8'd200);
                default: program_setting(8'($urandom_range(0, 8)),
                                         8'($urandom_range(8, 255)),
                                         8'($urandom_range(0, 255)));
            endcase
            run_scene(88);
        end
        no_idle = 1'b0;

        // Drain: wait for the last results, then keep watching for strays
        s_tvalid = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sdmd_pkg.sv
src/sdmd_ram.sv
src/sigma_delta_motion_detect_unit.sv
tb/tb.sv
